>>> rtl/tprle_pkg.sv
// Package for the tracker pattern run-length decoder: result status codes,
// controller/datapath command and status structs, marker table, default sizes.
// No dependencies.
package tprle_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DefRowsPerPattern  = 32;
  localparam int unsigned DefMaxPatterns     = 128;
  localparam int unsigned DefHeaderBytes     = 80;
  localparam int unsigned DefOrderEntryBytes = 14;

  // Header byte positions of the big-endian last-order word and pattern count.
  localparam int unsigned PosLastOrderHi = 12;
  localparam int unsigned PosLastOrderLo = 13;
  localparam int unsigned PosCountHi     = 14;
  localparam int unsigned PosCountLo     = 15;

  typedef enum logic [1:0] {
    ST_CELL       = 2'd0,
    ST_DONE       = 2'd1,
    ST_BAD_MARKER = 2'd2,
    ST_BAD_COUNT  = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    restart;      // start_of_module seen on the accepted word
    logic    hdr_step;     // header word: capture fields, advance position
    logic    skip_step;    // order-list word: advance position
    logic    mark_step;    // matching marker word
    logic    group_step;   // one byte of a four-byte group
    logic    emit_cell;    // push one expanded cell to the output register
    logic    emit_status;  // push a status result to the output register
    status_e status_code;
  } tprle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic hdr_bad;     // pattern count word is out of range
    logic hdr_end;     // this header word is the last one
    logic skip_end;    // this order-list word is the last one
    logic mark_match;  // byte matches the expected marker character
    logic gidx_last;   // byte is the fourth of a marker or group
    logic run_last;    // the cell being emitted is the last of its run
    logic ends_pat;    // the current run fills the pattern
    logic finished;    // the current run completes the last pattern
  } tprle_stat_t;

  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h70;  // 'p'
      2'd1:    c = 8'h61;  // 'a'
      default: c = 8'h74;  // 't'
    endcase
    return c;
  endfunction

endpackage

>>> rtl/tprle_if.sv
// Handshake interfaces of the tracker pattern run-length decoder:
// the byte input channel and the cell/status result channel. No dependencies.
interface tprle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] module_byte;
  logic       start_of_module;

  modport source (output valid, module_byte, start_of_module, input ready);
  modport sink (input valid, module_byte, start_of_module, output ready);
endinterface

interface tprle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] pattern_index;
  logic [4:0] row_index;
  logic [7:0] note_value;
  logic [7:0] instrument_effect;
  logic [7:0] effect_param;
  logic       last_of_run;

  modport source (output valid, status, pattern_index, row_index, note_value,
                  instrument_effect, effect_param, last_of_run, input ready);
  modport sink (input valid, status, pattern_index, row_index, note_value,
                instrument_effect, effect_param, last_of_run, output ready);
endinterface

>>> rtl/tracker_pattern_rle_decoder.sv
// Tracker pattern run-length decoder, top level.
// A status result is in the output register in the cycle after the word that causes it;
// cells of a run come from S_EMIT once the group's last byte is in. Throughput: one header,
// order-list or marker word per cycle while the output register is free; a group's last
// byte holds off input through its run (1 to ROWS_PER_PATTERN cells) and any done status.
// Reset (async, active low) returns to the header phase; the next word counts as byte zero.
module tracker_pattern_rle_decoder #(
  parameter int unsigned ROWS_PER_PATTERN  = tprle_pkg::DefRowsPerPattern,
  parameter int unsigned MAX_PATTERNS      = tprle_pkg::DefMaxPatterns,
  parameter int unsigned HEADER_BYTES      = tprle_pkg::DefHeaderBytes,
  parameter int unsigned ORDER_ENTRY_BYTES = tprle_pkg::DefOrderEntryBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tprle_in_if.sink    in_i,
  tprle_out_if.source out_o
);
  import tprle_pkg::*;

  // The controller decides, per accepted word, which phase it belongs to and
  // drives the datapath with one command struct; the datapath answers with
  // compare results on the current word and its counters.
  tprle_cmd_t  cmd;
  tprle_stat_t stat;

  tprle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .start_i    (in_i.start_of_module),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath owns the output register. A word is taken only while that
  // register can take a result, so a result that waits there unaccepted also
  // holds off the next word.
  tprle_datapath #(
    .ROWS_PER_PATTERN  (ROWS_PER_PATTERN),
    .MAX_PATTERNS      (MAX_PATTERNS),
    .HEADER_BYTES      (HEADER_BYTES),
    .ORDER_ENTRY_BYTES (ORDER_ENTRY_BYTES)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (in_i.module_byte),
    .start_i (in_i.start_of_module),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .out_o   (out_o)
  );

endmodule

>>> rtl/tprle_datapath.sv
// Datapath of the tracker pattern run-length decoder: position and group
// counters, held cell bytes, run counter and the output register.
// Depends on tprle_pkg and tprle_if.
module tprle_datapath #(
  parameter int unsigned ROWS_PER_PATTERN  = tprle_pkg::DefRowsPerPattern,
  parameter int unsigned MAX_PATTERNS      = tprle_pkg::DefMaxPatterns,
  parameter int unsigned HEADER_BYTES      = tprle_pkg::DefHeaderBytes,
  parameter int unsigned ORDER_ENTRY_BYTES = tprle_pkg::DefOrderEntryBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            byte_i,
  input  logic                  start_i,
  input  tprle_pkg::tprle_cmd_t cmd_i,
  output tprle_pkg::tprle_stat_t stat_o,
  tprle_out_if.source           out_o
);
  import tprle_pkg::*;

  // Largest position reached: end of the order list for the largest last order.
  localparam int unsigned PosMax = HEADER_BYTES + 65536 * ORDER_ENTRY_BYTES;
  localparam int unsigned PosW   = $clog2(PosMax + 1);
  localparam int unsigned RowW   = $clog2(ROWS_PER_PATTERN + 1);

  logic [PosW-1:0] pos_q, pos_d, pos_eff, start_q, start_d;
  logic [15:0]     lo_q, lo_d;
  logic [7:0]      total_q, total_d;
  logic [7:0]      pat_q, pat_d;
  logic [RowW-1:0] row_q, row_d, run_q, run_d, left;
  logic [1:0]      gidx_q, gidx_d;
  logic [7:0]      note_q, note_d, inst_q, inst_d, param_q, param_d;
  logic            ends_q, ends_d, fin_q, fin_d;
  logic [7:0]      run_raw;
  logic [8:0]      run_cmp;
  logic            run_clip, grp_ends;

  logic            ov_q, ov_d;
  logic [1:0]      os_q, os_d;
  logic [6:0]      op_q, op_d;
  logic [4:0]      or_q, or_d;
  logic [7:0]      on_q, on_d, oi_q, oi_d, oe_q, oe_d;
  logic            ol_q, ol_d;

  assign pos_eff  = start_i ? '0 : pos_q;
  assign left     = RowW'(ROWS_PER_PATTERN) - row_q;
  assign run_raw  = (byte_i == 8'd0) ? 8'd1 : byte_i;
  assign run_cmp  = {1'b0, run_raw};
  assign run_clip = run_cmp > 9'(left);
  assign grp_ends = run_cmp >= 9'(left);

  always_comb begin
    stat_o.out_free   = !ov_q || out_o.ready;
    stat_o.hdr_bad    = (pos_eff == PosW'(PosCountLo)) &&
                        ((total_q != 8'd0) || (byte_i == 8'd0) ||
                         ({1'b0, byte_i} > 9'(MAX_PATTERNS)));
    stat_o.hdr_end    = (pos_eff + PosW'(1)) >= PosW'(HEADER_BYTES);
    stat_o.skip_end   = (pos_q + PosW'(1)) >= start_q;
    stat_o.mark_match = byte_i == marker_char(gidx_q);
    stat_o.gidx_last  = gidx_q == 2'd3;
    stat_o.run_last   = run_q == RowW'(1);
    stat_o.ends_pat   = ends_q;
    stat_o.finished   = fin_q;
  end

  always_comb begin
    pos_d   = pos_q;
    start_d = start_q;
    lo_d    = lo_q;
    total_d = total_q;
    pat_d   = pat_q;
    row_d   = row_q;
    run_d   = run_q;
    gidx_d  = gidx_q;
    note_d  = note_q;
    inst_d  = inst_q;
    param_d = param_q;
    ends_d  = ends_q;
    fin_d   = fin_q;
    ov_d    = ov_q && !out_o.ready;
    os_d    = os_q;
    op_d    = op_q;
    or_d    = or_q;
    on_d    = on_q;
    oi_d    = oi_q;
    oe_d    = oe_q;
    ol_d    = ol_q;

    if (cmd_i.restart) begin
      pat_d   = '0;
      row_d   = '0;
      gidx_d  = '0;
      total_d = '0;
      lo_d    = '0;
    end

    if (cmd_i.hdr_step) begin
      pos_d = pos_eff + PosW'(1);
      if (pos_eff == PosW'(PosLastOrderHi)) begin
        lo_d = {byte_i, 8'd0};
      end else if (pos_eff == PosW'(PosLastOrderLo)) begin
        lo_d = {lo_q[15:8], byte_i};
      end else if (pos_eff == PosW'(PosCountHi)) begin
        total_d = byte_i;
        // The last-order word is complete here; fix the end of the order list.
        start_d = PosW'(HEADER_BYTES) +
                  PosW'((PosW'(lo_q) + PosW'(1)) * PosW'(ORDER_ENTRY_BYTES));
      end else if (pos_eff == PosW'(PosCountLo)) begin
        total_d = byte_i;
      end
    end

    if (cmd_i.skip_step) begin
      pos_d = pos_q + PosW'(1);
      if (stat_o.skip_end) begin
        gidx_d = '0;
      end
    end

    if (cmd_i.mark_step) begin
      if (gidx_q == 2'd3) begin
        gidx_d = '0;
        row_d  = '0;
      end else begin
        gidx_d = gidx_q + 2'd1;
      end
    end

    if (cmd_i.group_step) begin
      gidx_d = gidx_q + 2'd1;
      unique case (gidx_q)
        2'd0: note_d  = byte_i;
        2'd1: inst_d  = byte_i;
        2'd2: param_d = byte_i;
        default: begin
          run_d  = run_clip ? left : RowW'(run_raw);
          ends_d = grp_ends;
          fin_d  = grp_ends && ({1'b0, pat_q} + 9'd1 >= {1'b0, total_q});
        end
      endcase
    end

    if (cmd_i.emit_cell) begin
      ov_d  = 1'b1;
      os_d  = ST_CELL;
      op_d  = pat_q[6:0];
      or_d  = 5'(row_q);
      on_d  = note_q;
      oi_d  = inst_q;
      oe_d  = param_q;
      ol_d  = stat_o.run_last && !fin_q;
      row_d = row_q + RowW'(1);
      run_d = run_q - RowW'(1);
      if (stat_o.run_last && ends_q) begin
        row_d = '0;
        pat_d = pat_q + 8'd1;
      end
    end

    if (cmd_i.emit_status) begin
      ov_d = 1'b1;
      os_d = cmd_i.status_code;
      op_d = '0;
      or_d = '0;
      on_d = '0;
      oi_d = '0;
      oe_d = '0;
      ol_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      lo_q    <= '0;
      total_q <= '0;
      pat_q   <= '0;
      row_q   <= '0;
      run_q   <= '0;
      gidx_q  <= '0;
      ends_q  <= 1'b0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      start_q <= start_d;
      lo_q    <= lo_d;
      total_q <= total_d;
      pat_q   <= pat_d;
      row_q   <= row_d;
      run_q   <= run_d;
      gidx_q  <= gidx_d;
      ends_q  <= ends_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q  <= note_d;
    inst_q  <= inst_d;
    param_q <= param_d;
    os_q    <= os_d;
    op_q    <= op_d;
    or_q    <= or_d;
    on_q    <= on_d;
    oi_q    <= oi_d;
    oe_q    <= oe_d;
    ol_q    <= ol_d;
  end

  assign out_o.valid             = ov_q;
  assign out_o.status            = os_q;
  assign out_o.pattern_index     = op_q;
  assign out_o.row_index         = or_q;
  assign out_o.note_value        = on_q;
  assign out_o.instrument_effect = oi_q;
  assign out_o.effect_param      = oe_q;
  assign out_o.last_of_run       = ol_q;

endmodule

>>> rtl/tprle_ctrl.sv
// Controller of the tracker pattern run-length decoder: one-hot phase machine
// that issues datapath commands and runs the cell expansion. Depends on tprle_pkg.
module tprle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   start_i,
  output logic                   in_ready_o,
  input  tprle_pkg::tprle_stat_t stat_i,
  output tprle_pkg::tprle_cmd_t  cmd_o
);
  import tprle_pkg::*;

  typedef enum logic [6:0] {
    S_HEADER = 7'b0000001,
    S_SKIP   = 7'b0000010,
    S_MARKER = 7'b0000100,
    S_GROUP  = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_FINAL  = 7'b0100000,
    S_IDLE   = 7'b1000000
  } state_e;

  state_e state_q, state_d, eff;
  logic   take, acc;

  assign take       = (state_q != S_EMIT) && (state_q != S_FINAL);
  assign in_ready_o = take && stat_i.out_free;
  assign acc        = in_valid_i && in_ready_o;
  // A start marker puts the word back into the header phase at byte zero.
  assign eff        = start_i ? S_HEADER : state_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status_code = ST_CELL;
    if (acc) begin
      cmd_o.restart = start_i;
      unique case (eff)
        S_HEADER: begin
          if (stat_i.hdr_bad) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.status_code = ST_BAD_COUNT;
            state_d = S_IDLE;
          end else begin
            cmd_o.hdr_step = 1'b1;
            state_d = stat_i.hdr_end ? S_SKIP : S_HEADER;
          end
        end
        S_SKIP: begin
          cmd_o.skip_step = 1'b1;
          if (stat_i.skip_end) begin
            state_d = S_MARKER;
          end
        end
        S_MARKER: begin
          if (!stat_i.mark_match) begin
            cmd_o.emit_status = 1'b1;
            cmd_o.status_code = ST_BAD_MARKER;
            state_d = S_IDLE;
          end else begin
            cmd_o.mark_step = 1'b1;
            if (stat_i.gidx_last) begin
              state_d = S_GROUP;
            end
          end
        end
        S_GROUP: begin
          cmd_o.group_step = 1'b1;
          if (stat_i.gidx_last) begin
            state_d = S_EMIT;
          end
        end
        default: state_d = eff;
      endcase
    end else if (state_q == S_EMIT && stat_i.out_free) begin
      cmd_o.emit_cell = 1'b1;
      if (stat_i.run_last) begin
        if (stat_i.finished) begin
          state_d = S_FINAL;
        end else if (stat_i.ends_pat) begin
          state_d = S_MARKER;
        end else begin
          state_d = S_GROUP;
        end
      end
    end else if (state_q == S_FINAL && stat_i.out_free) begin
      cmd_o.emit_status = 1'b1;
      cmd_o.status_code = ST_DONE;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
